// ===== sv/mwsm_pkg.sv =====
// ----------------------------------------------------------------------------
// mwsm_pkg
// Shared widths, register codes, reset values and inter-stage request types
// of the mecanum wheel speed mixer.
// ----------------------------------------------------------------------------
package mwsm_pkg;

    localparam int VEL_W      = 18;
    localparam int LIM_W      = 17;
    localparam int WLIM_W     = 15;
    localparam int ROT_W      = 24;
    localparam int SCALE_W    = 32;
    localparam int RPM_W      = 16;
    localparam int FRAC_W     = 16;
    localparam int WHEELS     = 4;

    localparam int K_W        = ROT_W + 2;
    localparam int LIN_W      = VEL_W + 1;
    localparam int SUM_W      = 44;
    localparam int MAG_W      = SUM_W - 1;
    localparam int PHI_W      = MAG_W - FRAC_W + SCALE_W;
    localparam int PLO_W      = FRAC_W + SCALE_W;
    localparam int NUM_W      = MAG_W + WLIM_W;
    localparam int QUO_W      = WLIM_W;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_TDATA_W  = 56;
    localparam int M_TDATA_W  = WHEELS * RPM_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LIMIT_VX    = 3'd0,
        CFG_LIMIT_VY    = 3'd1,
        CFG_LIMIT_VW    = 3'd2,
        CFG_LIMIT_WHEEL = 3'd3,
        CFG_ROT_BASE    = 3'd4,
        CFG_ROT_X_OFF   = 3'd5,
        CFG_ROT_Y_OFF   = 3'd6,
        CFG_RPM_SCALE   = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic [LIM_W-1:0]          limit_vx;
        logic [LIM_W-1:0]          limit_vy;
        logic [LIM_W-1:0]          limit_vw;
        logic [WLIM_W-1:0]         limit_wheel;
        logic [ROT_W-1:0]          rot_base;
        logic signed [ROT_W-1:0]   rot_x_off;
        logic signed [ROT_W-1:0]   rot_y_off;
        logic [SCALE_W-1:0]        rpm_scale;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        limit_vx:    17'd50000,
        limit_vy:    17'd50000,
        limit_vw:    17'd50000,
        limit_wheel: 15'd8000,
        rot_base:    24'd343120,
        rot_x_off:   24'sd0,
        rot_y_off:   24'sd0,
        rpm_scale:   32'd28374591
    };

    // wheel order: front right, front left, back left, back right
    typedef struct packed {
        logic [WHEELS-1:0]             neg;
        logic [WHEELS-1:0][MAG_W-1:0]  mag;
    } t_mag_req;

    typedef struct packed {
        logic [WHEELS-1:0]             neg;
        logic                          scaled;
        logic [MAG_W-1:0]              mx;
        logic [WHEELS-1:0][NUM_W-1:0]  num;
        logic [WHEELS-1:0][QUO_W-1:0]  low;
    } t_div_req;

    typedef struct packed {
        logic [WHEELS-1:0]             neg;
        logic                          scaled;
        logic [WHEELS-1:0][QUO_W-1:0]  quo;
        logic [WHEELS-1:0][QUO_W-1:0]  low;
    } t_div_rsp;

endpackage

// ===== sv/mwsm_mix.sv =====
// ----------------------------------------------------------------------------
// mwsm_mix
// Clamp, rotation factors, mixing products, wheel sums and magnitudes.
// Four register stages.
// ----------------------------------------------------------------------------
module mwsm_mix (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mwsm_pkg::t_cfg      i_cfg,
    input  logic                i_vld,
    output logic                o_rdy,
    input  logic signed [mwsm_pkg::VEL_W-1:0] i_vel_x,
    input  logic signed [mwsm_pkg::VEL_W-1:0] i_vel_y,
    input  logic signed [mwsm_pkg::VEL_W-1:0] i_vel_w,
    output logic                o_vld,
    input  logic                i_rdy,
    output mwsm_pkg::t_mag_req  o_req
);

    localparam int STAGES = 4;
    localparam int VEL_W  = mwsm_pkg::VEL_W;
    localparam int LIM_W  = mwsm_pkg::LIM_W;
    localparam int K_W    = mwsm_pkg::K_W;
    localparam int LIN_W  = mwsm_pkg::LIN_W;
    localparam int SUM_W  = mwsm_pkg::SUM_W;
    localparam int MAG_W  = mwsm_pkg::MAG_W;
    localparam int FRAC_W = mwsm_pkg::FRAC_W;
    localparam int WHEELS = mwsm_pkg::WHEELS;

    function automatic logic signed [VEL_W-1:0] clamp_sym(
        input logic signed [VEL_W-1:0] v,
        input logic [LIM_W-1:0]        lim
    );
        logic signed [VEL_W:0] l;
        logic signed [VEL_W:0] vv;
        logic signed [VEL_W:0] r;
        l  = $signed({1'b0, lim});
        vv = {v[VEL_W-1], v};
        if (vv < -l) begin
            r = -l;
        end else if (vv > l) begin
            r = l;
        end else begin
            r = vv;
        end
        return $signed(r[VEL_W-1:0]);
    endfunction

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] w_en;

    assign w_en[STAGES-1] = !r_vld[STAGES-1] || i_rdy;
    for (genvar g = 0; g < STAGES - 1; g++) begin : g_en
        assign w_en[g] = !r_vld[g] || w_en[g+1];
    end
    assign n_vld = {r_vld[STAGES-2:0], i_vld};
    assign o_rdy = w_en[0];
    assign o_vld = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // stage 1: clamp and rotation factors
    logic signed [VEL_W-1:0] r_s1_vx, r_s1_vy, r_s1_vw;
    logic signed [K_W-1:0]   r_s1_k [WHEELS];
    logic signed [K_W-1:0]   n_s1_k [WHEELS];
    logic signed [K_W-1:0]   w_base, w_xo, w_yo;

    assign w_base = $signed({2'b00, i_cfg.rot_base});
    assign w_xo   = K_W'(i_cfg.rot_x_off);
    assign w_yo   = K_W'(i_cfg.rot_y_off);

    always_comb begin
        n_s1_k[0] = w_base - w_xo + w_yo;
        n_s1_k[1] = w_base - w_xo - w_yo;
        n_s1_k[2] = w_base + w_xo - w_yo;
        n_s1_k[3] = w_base + w_xo + w_yo;
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_vx <= clamp_sym(i_vel_x, i_cfg.limit_vx);
            r_s1_vy <= clamp_sym(i_vel_y, i_cfg.limit_vy);
            r_s1_vw <= clamp_sym(i_vel_w, i_cfg.limit_vw);
            r_s1_k  <= n_s1_k;
        end
    end

    // stage 2: linear terms and rotation products
    logic signed [LIN_W-1:0] r_s2_lin [WHEELS];
    logic signed [LIN_W-1:0] n_s2_lin [WHEELS];
    logic signed [SUM_W-1:0] r_s2_prd [WHEELS];
    logic signed [SUM_W-1:0] n_s2_prd [WHEELS];
    logic signed [LIN_W-1:0] w_vx, w_vy;

    assign w_vx = LIN_W'(r_s1_vx);
    assign w_vy = LIN_W'(r_s1_vy);

    always_comb begin
        n_s2_lin[0] = -w_vx + w_vy;
        n_s2_lin[1] =  w_vx + w_vy;
        n_s2_lin[2] =  w_vx - w_vy;
        n_s2_lin[3] = -w_vx - w_vy;
        for (int i = 0; i < WHEELS; i++) begin
            n_s2_prd[i] = SUM_W'(r_s1_vw) * SUM_W'(r_s1_k[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_lin <= n_s2_lin;
            r_s2_prd <= n_s2_prd;
        end
    end

    // stage 3: Q16 wheel sums
    logic signed [SUM_W-1:0] r_s3_sum [WHEELS];
    logic signed [SUM_W-1:0] n_s3_sum [WHEELS];

    always_comb begin
        for (int i = 0; i < WHEELS; i++) begin
            n_s3_sum[i] = (SUM_W'(r_s2_lin[i]) <<< FRAC_W) + r_s2_prd[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s3_sum <= n_s3_sum;
        end
    end

    // stage 4: sign and magnitude
    mwsm_pkg::t_mag_req r_s4_req;
    mwsm_pkg::t_mag_req n_s4_req;

    always_comb begin
        for (int i = 0; i < WHEELS; i++) begin
            n_s4_req.neg[i] = r_s3_sum[i][SUM_W-1];
            n_s4_req.mag[i] = MAG_W'(r_s3_sum[i][SUM_W-1] ? -r_s3_sum[i] : r_s3_sum[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4_req <= n_s4_req;
        end
    end

    assign o_req = r_s4_req;

endmodule

// ===== sv/mwsm_ratio.sv =====
// ----------------------------------------------------------------------------
// mwsm_ratio
// Rpm ratio multiply, largest wheel, limit test and divider numerators.
// Five register stages.
// ----------------------------------------------------------------------------
module mwsm_ratio (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mwsm_pkg::t_cfg      i_cfg,
    input  logic                i_vld,
    output logic                o_rdy,
    input  mwsm_pkg::t_mag_req  i_req,
    output logic                o_vld,
    input  logic                i_rdy,
    output mwsm_pkg::t_div_req  o_req
);

    localparam int STAGES = 5;
    localparam int MAG_W  = mwsm_pkg::MAG_W;
    localparam int FRAC_W = mwsm_pkg::FRAC_W;
    localparam int PHI_W  = mwsm_pkg::PHI_W;
    localparam int PLO_W  = mwsm_pkg::PLO_W;
    localparam int NUM_W  = mwsm_pkg::NUM_W;
    localparam int QUO_W  = mwsm_pkg::QUO_W;
    localparam int WHEELS = mwsm_pkg::WHEELS;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] w_en;

    assign w_en[STAGES-1] = !r_vld[STAGES-1] || i_rdy;
    for (genvar g = 0; g < STAGES - 1; g++) begin : g_en
        assign w_en[g] = !r_vld[g] || w_en[g+1];
    end
    assign n_vld = {r_vld[STAGES-2:0], i_vld};
    assign o_rdy = w_en[0];
    assign o_vld = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    // stage 1: split products with the Q0.32 ratio
    logic [WHEELS-1:0] r_s1_neg;
    logic [PHI_W-1:0]  r_s1_phi [WHEELS];
    logic [PHI_W-1:0]  n_s1_phi [WHEELS];
    logic [PLO_W-1:0]  r_s1_plo [WHEELS];
    logic [PLO_W-1:0]  n_s1_plo [WHEELS];

    always_comb begin
        for (int i = 0; i < WHEELS; i++) begin
            n_s1_phi[i] = PHI_W'(i_req.mag[i][MAG_W-1:FRAC_W]) * PHI_W'(i_cfg.rpm_scale);
            n_s1_plo[i] = PLO_W'(i_req.mag[i][FRAC_W-1:0]) * PLO_W'(i_cfg.rpm_scale);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[0]) begin
            r_s1_neg <= i_req.neg;
            r_s1_phi <= n_s1_phi;
            r_s1_plo <= n_s1_plo;
        end
    end

    // stage 2: wheel speed magnitude, Q16 rpm
    logic [WHEELS-1:0] r_s2_neg;
    logic [MAG_W-1:0]  r_s2_w [WHEELS];
    logic [MAG_W-1:0]  n_s2_w [WHEELS];
    logic [PHI_W-1:0]  w_s2_t [WHEELS];

    always_comb begin
        for (int i = 0; i < WHEELS; i++) begin
            w_s2_t[i] = r_s1_phi[i] + PHI_W'(r_s1_plo[i][PLO_W-1:FRAC_W]);
            n_s2_w[i] = w_s2_t[i][PHI_W-1:FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[1]) begin
            r_s2_neg <= r_s1_neg;
            r_s2_w   <= n_s2_w;
        end
    end

    // stage 3: pairwise maxima
    logic [WHEELS-1:0] r_s3_neg;
    logic [MAG_W-1:0]  r_s3_w [WHEELS];
    logic [MAG_W-1:0]  r_s3_m01, r_s3_m23;

    always_ff @(posedge i_clk) begin
        if (w_en[2]) begin
            r_s3_neg <= r_s2_neg;
            r_s3_w   <= r_s2_w;
            r_s3_m01 <= (r_s2_w[0] > r_s2_w[1]) ? r_s2_w[0] : r_s2_w[1];
            r_s3_m23 <= (r_s2_w[2] > r_s2_w[3]) ? r_s2_w[2] : r_s2_w[3];
        end
    end

    // stage 4: overall maximum and limit test
    logic [WHEELS-1:0] r_s4_neg;
    logic [MAG_W-1:0]  r_s4_w [WHEELS];
    logic [MAG_W-1:0]  r_s4_mx;
    logic [MAG_W-1:0]  n_s4_mx;
    logic              r_s4_scl;
    logic [MAG_W-1:0]  w_lim16;

    assign n_s4_mx = (r_s3_m01 > r_s3_m23) ? r_s3_m01 : r_s3_m23;
    assign w_lim16 = MAG_W'({i_cfg.limit_wheel, {FRAC_W{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (w_en[3]) begin
            r_s4_neg <= r_s3_neg;
            r_s4_w   <= r_s3_w;
            r_s4_mx  <= n_s4_mx;
            r_s4_scl <= n_s4_mx > w_lim16;
        end
    end

    // stage 5: numerators and unscaled integer rpm
    mwsm_pkg::t_div_req r_s5_req;
    mwsm_pkg::t_div_req n_s5_req;

    always_comb begin
        n_s5_req.neg    = r_s4_neg;
        n_s5_req.scaled = r_s4_scl;
        n_s5_req.mx     = r_s4_mx;
        for (int i = 0; i < WHEELS; i++) begin
            n_s5_req.num[i] = NUM_W'(r_s4_w[i]) * NUM_W'(i_cfg.limit_wheel);
            n_s5_req.low[i] = r_s4_w[i][FRAC_W+QUO_W-1:FRAC_W];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en[4]) begin
            r_s5_req <= n_s5_req;
        end
    end

    assign o_req = r_s5_req;

endmodule

// ===== sv/mwsm_div.sv =====
// ----------------------------------------------------------------------------
// mwsm_div
// Four-lane restoring divider, one quotient bit per register stage,
// all lanes sharing the same divisor (largest wheel).
// ----------------------------------------------------------------------------
module mwsm_div (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_vld,
    output logic                o_rdy,
    input  mwsm_pkg::t_div_req  i_req,
    output logic                o_vld,
    input  logic                i_rdy,
    output mwsm_pkg::t_div_rsp  o_rsp
);

    localparam int QUO_W  = mwsm_pkg::QUO_W;
    localparam int STAGES = QUO_W;
    localparam int MAG_W  = mwsm_pkg::MAG_W;
    localparam int NUM_W  = mwsm_pkg::NUM_W;
    localparam int WHEELS = mwsm_pkg::WHEELS;

    typedef struct packed {
        logic [WHEELS-1:0]             neg;
        logic                          scaled;
        logic [MAG_W-1:0]              mx;
        logic [WHEELS-1:0][NUM_W-1:0]  rem;
        logic [WHEELS-1:0][QUO_W-1:0]  quo;
        logic [WHEELS-1:0][QUO_W-1:0]  low;
    } t_stg;

    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] n_vld;
    logic [STAGES-1:0] w_en;

    assign w_en[STAGES-1] = !r_vld[STAGES-1] || i_rdy;
    for (genvar g = 0; g < STAGES - 1; g++) begin : g_en
        assign w_en[g] = !r_vld[g] || w_en[g+1];
    end
    assign n_vld = {r_vld[STAGES-2:0], i_vld};
    assign o_rdy = w_en[0];
    assign o_vld = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (w_en[k]) begin
                    r_vld[k] <= n_vld[k];
                end
            end
        end
    end

    t_stg r_stg [STAGES];
    t_stg w_src [STAGES];
    t_stg n_stg [STAGES];

    for (genvar j = 0; j < STAGES; j++) begin : g_stg
        localparam int SH = STAGES - 1 - j;
        logic [NUM_W-1:0] w_dvs;

        if (j == 0) begin : g_first
            assign w_src[j] = {i_req.neg, i_req.scaled, i_req.mx, i_req.num,
                               {(WHEELS*QUO_W){1'b0}}, i_req.low};
        end else begin : g_next
            assign w_src[j] = r_stg[j-1];
        end

        assign w_dvs = NUM_W'(w_src[j].mx) << SH;

        always_comb begin
            n_stg[j] = w_src[j];
            for (int i = 0; i < WHEELS; i++) begin
                if (w_src[j].rem[i] >= w_dvs) begin
                    n_stg[j].rem[i]     = w_src[j].rem[i] - w_dvs;
                    n_stg[j].quo[i][SH] = 1'b1;
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (w_en[j]) begin
                r_stg[j] <= n_stg[j];
            end
        end
    end

    assign o_rsp.neg    = r_stg[STAGES-1].neg;
    assign o_rsp.scaled = r_stg[STAGES-1].scaled;
    assign o_rsp.quo    = r_stg[STAGES-1].quo;
    assign o_rsp.low    = r_stg[STAGES-1].low;

endmodule

// ===== sv/mecanum_wheel_speed_mixer_top.sv =====
// ----------------------------------------------------------------------------
// mecanum_wheel_speed_mixer_top
// Mecanum inverse kinematics: chassis command to four wheel rpm values.
// ----------------------------------------------------------------------------
// Input stream carries one chassis command (vel_x, vel_y, vel_w) per request;
// output stream returns one request of four wheel speeds, with tuser set when
// all wheels were scaled down to the wheel limit.
// Config channel writes the eight limit / geometry / ratio registers; it is
// always ready and should only be used while the pipeline is empty.
// Pipeline: 25 register stages (4 mixing, 5 ratio/limit, 15 divider bit
// stages, 1 output register). Throughput: one request per cycle while the
// output is not stalled; each stage takes a new request whenever it is empty
// or the stage after it advances.
// Reset: synchronous, active low; clears all valid bits and restores the
// register defaults. No clearing pass.
// Stall: a held output only stops the stages that are full; empty stages
// further back keep taking requests, so the input stays ready until the
// pipeline is full. Nothing is dropped or repeated.
// ----------------------------------------------------------------------------
module mecanum_wheel_speed_mixer_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    output logic                                 o_s_tready,
    // vel_x [17:0], vel_y [35:18], vel_w [53:36], zero [55:54]
    input  logic [mwsm_pkg::S_TDATA_W-1:0]       i_s_tdata,
    output logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    // rpm_front_right [15:0], rpm_front_left [31:16],
    // rpm_back_left [47:32], rpm_back_right [63:48]
    output logic [mwsm_pkg::M_TDATA_W-1:0]       o_m_tdata,
    // was_scaled [0]
    output logic                                 o_m_tuser,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [mwsm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mwsm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    localparam int VEL_W  = mwsm_pkg::VEL_W;
    localparam int LIM_W  = mwsm_pkg::LIM_W;
    localparam int WLIM_W = mwsm_pkg::WLIM_W;
    localparam int ROT_W  = mwsm_pkg::ROT_W;
    localparam int RPM_W  = mwsm_pkg::RPM_W;
    localparam int QUO_W  = mwsm_pkg::QUO_W;
    localparam int WHEELS = mwsm_pkg::WHEELS;

    // configuration registers
    mwsm_pkg::t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= mwsm_pkg::CFG_RESET;
        end else if (i_cfg_valid) begin
            case (mwsm_pkg::t_cfg_idx'(i_cfg_index))
                mwsm_pkg::CFG_LIMIT_VX:    r_cfg.limit_vx    <= i_cfg_data[LIM_W-1:0];
                mwsm_pkg::CFG_LIMIT_VY:    r_cfg.limit_vy    <= i_cfg_data[LIM_W-1:0];
                mwsm_pkg::CFG_LIMIT_VW:    r_cfg.limit_vw    <= i_cfg_data[LIM_W-1:0];
                mwsm_pkg::CFG_LIMIT_WHEEL: r_cfg.limit_wheel <= i_cfg_data[WLIM_W-1:0];
                mwsm_pkg::CFG_ROT_BASE:    r_cfg.rot_base    <= i_cfg_data[ROT_W-1:0];
                mwsm_pkg::CFG_ROT_X_OFF:   r_cfg.rot_x_off   <= $signed(i_cfg_data[ROT_W-1:0]);
                mwsm_pkg::CFG_ROT_Y_OFF:   r_cfg.rot_y_off   <= $signed(i_cfg_data[ROT_W-1:0]);
                mwsm_pkg::CFG_RPM_SCALE:   r_cfg.rpm_scale   <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    // pipeline
    logic                mix_vld, mix_rdy;
    mwsm_pkg::t_mag_req  mix_req;
    logic                rat_vld, rat_rdy;
    mwsm_pkg::t_div_req  rat_req;
    logic                div_vld, div_rdy;
    mwsm_pkg::t_div_rsp  div_rsp;
    logic                w_out_en;

    mwsm_mix u_mix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (i_s_tvalid),
        .o_rdy   (o_s_tready),
        .i_vel_x ($signed(i_s_tdata[VEL_W-1:0])),
        .i_vel_y ($signed(i_s_tdata[2*VEL_W-1:VEL_W])),
        .i_vel_w ($signed(i_s_tdata[3*VEL_W-1:2*VEL_W])),
        .o_vld   (mix_vld),
        .i_rdy   (mix_rdy),
        .o_req   (mix_req)
    );

    mwsm_ratio u_ratio (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_vld   (mix_vld),
        .o_rdy   (mix_rdy),
        .i_req   (mix_req),
        .o_vld   (rat_vld),
        .i_rdy   (rat_rdy),
        .o_req   (rat_req)
    );

    mwsm_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (rat_vld),
        .o_rdy   (rat_rdy),
        .i_req   (rat_req),
        .o_vld   (div_vld),
        .i_rdy   (div_rdy),
        .o_rsp   (div_rsp)
    );

    // output register: select scaled or unscaled, apply sign
    logic                   r_m_tvalid;
    logic [RPM_W*WHEELS-1:0] r_m_tdata;
    logic                   r_m_tuser;
    logic [RPM_W*WHEELS-1:0] n_m_tdata;
    logic [QUO_W-1:0]       w_abs [WHEELS];

    assign w_out_en = !r_m_tvalid || i_m_tready;
    assign div_rdy  = w_out_en;

    always_comb begin
        for (int i = 0; i < WHEELS; i++) begin
            w_abs[i] = div_rsp.scaled ? div_rsp.quo[i] : div_rsp.low[i];
            n_m_tdata[i*RPM_W +: RPM_W] = div_rsp.neg[i] ? -RPM_W'(w_abs[i])
                                                         :  RPM_W'(w_abs[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_out_en) begin
            r_m_tvalid <= div_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_en && div_vld) begin
            r_m_tdata <= n_m_tdata;
            r_m_tuser <= div_rsp.scaled;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

endmodule

// ===== sv/mwsm_checker.sv =====
// ----------------------------------------------------------------------------
// mwsm_checker
// Port-level checks on the wheel speed mixer, bound to the top level.
// ----------------------------------------------------------------------------
module mwsm_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_s_tvalid,
    input  logic                                 o_s_tready,
    input  logic [mwsm_pkg::S_TDATA_W-1:0]       i_s_tdata,
    input  logic                                 o_m_tvalid,
    input  logic                                 i_m_tready,
    input  logic [mwsm_pkg::M_TDATA_W-1:0]       o_m_tdata,
    input  logic                                 o_m_tuser,
    input  logic                                 i_cfg_valid,
    input  logic                                 o_cfg_ready,
    input  logic [mwsm_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [mwsm_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    // held output request keeps its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
                                      && $stable(o_m_tuser))
        else $error("output request changed while stalled");

    // with the output register empty every stage can advance
    a_rdy_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input not ready while output empty");

    // both result paths give a 15-bit magnitude, so no wheel speed is 16'h8000
    a_rpm_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[15:0] != 16'h8000) && (o_m_tdata[31:16] != 16'h8000)
                       && (o_m_tdata[47:32] != 16'h8000) && (o_m_tdata[63:48] != 16'h8000))
        else $error("wheel speed out of range");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind mecanum_wheel_speed_mixer_top mwsm_checker u_mwsm_checker (.*);
